/* design/isrt_pkg.sv */
// Shared types and constants for the insertion sorter.
package isrt_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } isrt_state_e;

  // Controller to datapath
  typedef struct packed {
    logic insert;     // insert value_i into the row
    logic mark_drop;  // store full: drop value, raise overflow
    logic shift;      // pop head, shift row down by one
    logic clear_ovf;  // end of run: clear overflow flag
  } isrt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;       // fill count at capacity
    logic last;       // exactly one entry left
  } isrt_status_t;

endpackage

/* design/isrt_datapath.sv */
// Insertion sorter datapath: row of compare/shift cells, fill count, overflow flag.
module isrt_datapath import isrt_pkg::*; #(
  parameter int Capacity = CAPACITY_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  isrt_cmd_t                 cmd_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output isrt_status_t              status_o,
  output logic signed [VALUE_W-1:0] head_o,
  output logic                      dropped_o
);

  localparam int CntW = $clog2(Capacity + 1);

  logic signed [VALUE_W-1:0] cell_q [Capacity];
  logic signed [VALUE_W-1:0] cell_d [Capacity];
  logic [Capacity-1:0]       above;
  logic [CntW-1:0]           count_q, count_d;
  logic                      ovf_q, ovf_d;

  // Entries at or past the fill count act as +infinity.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    assign above[i] = (CntW'(i) >= count_q) || (cell_q[i] > value_i);

    if (i == 0) begin : g_first
      always_comb begin
        if (cmd_i.shift) begin
          cell_d[i] = (Capacity > 1) ? cell_q[(Capacity > 1) ? 1 : 0] : cell_q[i];
        end else if (above[i]) begin
          cell_d[i] = value_i;
        end else begin
          cell_d[i] = cell_q[i];
        end
      end
    end else begin : g_rest
      always_comb begin
        if (cmd_i.shift) begin
          cell_d[i] = (i < Capacity - 1) ? cell_q[(i < Capacity - 1) ? i + 1 : i] : cell_q[i];
        end else if (above[i]) begin
          cell_d[i] = above[i-1] ? cell_q[i-1] : value_i;
        end else begin
          cell_d[i] = cell_q[i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert || cmd_i.shift) begin
        cell_q[i] <= cell_d[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.shift) begin
      count_d = count_q - CntW'(1);
    end
    ovf_d = ovf_q;
    if (cmd_i.mark_drop) begin
      ovf_d = 1'b1;
    end else if (cmd_i.clear_ovf) begin
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign status_o.full = (count_q == CntW'(Capacity));
  assign status_o.last = (count_q == CntW'(1));
  assign head_o        = cell_q[0];
  assign dropped_o     = ovf_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("fill count beyond capacity");

  a_shift_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> count_q != '0)
    else $error("pop from empty row");

  a_no_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> !status_o.full)
    else $error("insert into full row");

  a_clear_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_ovf |=> (count_q == '0) && !ovf_q)
    else $error("state not emptied after run");

endmodule

/* design/isrt_ctrl.sv */
// Insertion sorter controller: load/emit state machine.
module isrt_ctrl import isrt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         final_item_i,
  input  isrt_status_t status_i,
  output isrt_cmd_t    cmd_o,
  output logic         busy_o,
  output logic         emit_o
);

  isrt_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && final_item_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b0;
    emit_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.insert    = start_i && !status_i.full;
        cmd_o.mark_drop = start_i && status_i.full;
      end
      ST_EMIT: begin
        busy_o          = 1'b1;
        emit_o          = 1'b1;
        cmd_o.shift     = 1'b1;
        cmd_o.clear_ovf = status_i.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/insertion_sorter_core.sv */
// Insertion sorter top level: stable streaming sort of signed 32-bit values.
//
// One value is taken per transfer (start high while busy low) and inserted into
// an ascending row of Capacity register cells; every cell compares against the
// new value in parallel and shifts up when it holds a strictly greater entry,
// so equal values keep arrival order. While a set loads the block accepts a
// value every cycle. The transfer flagged final_item_i is inserted too, then
// busy rises and the list streams out from the head of the row, one result per
// cycle with result_valid_o high for exactly that cycle; after the last stored
// value the row is empty and new transfers are taken again. Results cannot be
// held off by the receiver. Values that arrive while the row is full are
// dropped; dropped_o is then high on every result of that run, and clears
// when the run ends.
module insertion_sorter_core import isrt_pkg::*; #(
  parameter int Capacity = CAPACITY_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      final_item_i,
  output logic                      result_valid_o,
  output logic signed [VALUE_W-1:0] sorted_value_o,
  output logic                      last_out_o,
  output logic                      dropped_o
);

  isrt_cmd_t    cmd;
  isrt_status_t status;
  logic         emit;
  logic         dropped;

  isrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .final_item_i(final_item_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .emit_o      (emit)
  );

  isrt_datapath #(
    .Capacity(Capacity)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .value_i  (value_i),
    .status_o (status),
    .head_o   (sorted_value_o),
    .dropped_o(dropped)
  );

  // Head cell is presented while emitting; the row pops each cycle.
  assign result_valid_o = emit;
  assign last_out_o     = emit && status.last;
  assign dropped_o      = emit && dropped;

endmodule
